// ===== rtl/pal_pkg.sv =====
// Shared types, codes and command/status structs for the positional array list.
`default_nettype none

package pal_pkg;

    // Action codes carried in the action field of an input item
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_GET    = 2'd2;
    localparam logic [1:0] ACT_LOCATE = 2'd3;

    // Input item
    typedef struct packed {
        logic [1:0]         action;
        logic [4:0]         position;
        logic signed [31:0] item_value;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic               ok;
        logic signed [31:0] result_value;
        logic [4:0]         result_position;
        logic [4:0]         count;
    } t_out_item;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_RD,
        S_INS_WR,
        S_DEL_TAKE,
        S_DEL_SHRD,
        S_DEL_SHWR,
        S_GET_TAKE,
        S_LOC_RD,
        S_LOC_CMP,
        S_FINISH
    } t_state;

    // Operations on the walking index
    typedef enum logic [2:0] {
        J_HOLD,
        J_LOAD_LEN,
        J_LOAD_POS,
        J_LOAD_ZERO,
        J_DEC,
        J_INC
    } t_j_op;

    // Memory read address select
    typedef enum logic [1:0] {
        RA_J_M1,
        RA_J,
        RA_POS_M1
    } t_rd_sel;

    // Memory write select: address and the data that goes with it
    typedef enum logic [1:0] {
        WA_J_SHIFT,
        WA_J_M1_SHIFT,
        WA_POS_M1_VALUE
    } t_wr_sel;

    // Length update
    typedef enum logic [1:0] {
        LEN_HOLD,
        LEN_INC,
        LEN_DEC
    } t_len_op;

    // Controller to datapath
    typedef struct packed {
        logic    load_item;
        t_j_op   j_op;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    wr_en;
        t_wr_sel wr_sel;
        t_len_op len_op;
        logic    capture_rv;
        logic    set_ok;
        logic    set_rp;
        logic    out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] action;
        logic       pos_valid;
        logic       ins_valid;
        logic       j_ge_pos;
        logic       j_lt_len;
        logic       match;
        logic       out_free;
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/pal_dpath.sv =====
// Datapath: entry memory, list length, walking index, result and output registers.
`default_nettype none

module pal_dpath #(
    parameter int CAPACITY = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  pal_pkg::t_in_item   i_item,
    input  pal_pkg::t_cmd       i_cmd,
    input  wire                 i_stall,
    output pal_pkg::t_status    o_status,
    output logic                o_valid,
    output pal_pkg::t_out_item  o_item
);
    import pal_pkg::*;

    localparam int LW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = (LW > 5) ? LW : 5;

    logic signed [31:0] mem [CAPACITY];

    logic [LW-1:0]      r_len;
    logic [CW-1:0]      r_j;
    logic [CW-1:0]      n_j;
    logic [1:0]         r_act;
    logic [4:0]         r_pos;
    logic signed [31:0] r_val;
    logic signed [31:0] r_rdata;
    logic               r_ok;
    logic signed [31:0] r_rv;
    logic [4:0]         r_rp;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [CW-1:0]      len_ext;
    logic [CW-1:0]      pos_ext;
    logic [CW-1:0]      pos_m1;
    logic [CW-1:0]      j_m1;
    logic [CW-1:0]      j_p1;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_data;

    // Widen the compare operands to one common width
    assign len_ext = CW'(r_len);
    assign pos_ext = CW'(r_pos);
    assign pos_m1  = pos_ext - CW'(1);
    assign j_m1    = r_j - CW'(1);
    assign j_p1    = r_j + CW'(1);

    // Status for the controller
    assign o_status.action    = r_act;
    assign o_status.pos_valid = (r_pos != 5'd0) && (pos_ext <= len_ext);
    assign o_status.ins_valid = (r_pos != 5'd0) && (pos_ext <= len_ext + CW'(1))
                                && (len_ext < CW'(CAPACITY));
    assign o_status.j_ge_pos  = (r_j >= pos_ext);
    assign o_status.j_lt_len  = (r_j < len_ext);
    assign o_status.match     = (r_rdata == r_val);
    assign o_status.out_free  = !r_out_valid || !i_stall;

    // Select memory read address
    always_comb begin
        case (i_cmd.rd_sel)
            RA_J_M1:   rd_addr = j_m1[AW-1:0];
            RA_J:      rd_addr = r_j[AW-1:0];
            RA_POS_M1: rd_addr = pos_m1[AW-1:0];
            default:   rd_addr = r_j[AW-1:0];
        endcase
    end

    // Select memory write address and data
    always_comb begin
        case (i_cmd.wr_sel)
            WA_J_SHIFT: begin
                wr_addr = r_j[AW-1:0];
                wr_data = r_rdata;
            end
            WA_J_M1_SHIFT: begin
                wr_addr = j_m1[AW-1:0];
                wr_data = r_rdata;
            end
            WA_POS_M1_VALUE: begin
                wr_addr = pos_m1[AW-1:0];
                wr_data = r_val;
            end
            default: begin
                wr_addr = r_j[AW-1:0];
                wr_data = r_rdata;
            end
        endcase
    end

    // Entry memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // Next walking index
    always_comb begin
        case (i_cmd.j_op)
            J_HOLD:      n_j = r_j;
            J_LOAD_LEN:  n_j = len_ext;
            J_LOAD_POS:  n_j = pos_ext;
            J_LOAD_ZERO: n_j = '0;
            J_DEC:       n_j = j_m1;
            J_INC:       n_j = j_p1;
            default:     n_j = r_j;
        endcase
    end

    // Latch item, advance index, collect result fields
    always_ff @(posedge i_clk) begin
        r_j <= n_j;
        if (i_cmd.load_item) begin
            r_act <= i_item.action;
            r_pos <= i_item.position;
            r_val <= i_item.item_value;
            r_ok  <= 1'b0;
            r_rv  <= '0;
            r_rp  <= '0;
        end else begin
            if (i_cmd.capture_rv) begin
                r_rv <= r_rdata;
            end
            if (i_cmd.set_ok) begin
                r_ok <= 1'b1;
            end
            if (i_cmd.set_rp) begin
                r_rp <= j_p1[4:0];
            end
        end
        if (i_cmd.out_load) begin
            r_out.ok              <= r_ok;
            r_out.result_value    <= r_rv;
            r_out.result_position <= r_rp;
            r_out.count           <= len_ext[4:0];
        end
    end

    // List length and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (i_cmd.len_op)
                LEN_INC: r_len <= r_len + LW'(1);
                LEN_DEC: r_len <= r_len - LW'(1);
                default: r_len <= r_len;
            endcase
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

`default_nettype wire

// ===== rtl/pal_ctrl.sv =====
// Controller: sequences insert, delete, get and locate over the entry memory.
`default_nettype none

module pal_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    input  pal_pkg::t_status  i_status,
    output logic              o_stall,
    output pal_pkg::t_cmd     o_cmd
);
    import pal_pkg::*;

    t_state r_state;
    t_state n_state;

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                case (i_status.action)
                    ACT_INSERT: n_state = i_status.ins_valid ? S_INS_RD : S_FINISH;
                    ACT_DELETE: n_state = i_status.pos_valid ? S_DEL_TAKE : S_FINISH;
                    ACT_GET:    n_state = i_status.pos_valid ? S_GET_TAKE : S_FINISH;
                    default:    n_state = S_LOC_RD;
                endcase
            end
            S_INS_RD:   n_state = i_status.j_ge_pos ? S_INS_WR : S_FINISH;
            S_INS_WR:   n_state = S_INS_RD;
            S_DEL_TAKE: n_state = S_DEL_SHRD;
            S_DEL_SHRD: n_state = i_status.j_lt_len ? S_DEL_SHWR : S_FINISH;
            S_DEL_SHWR: n_state = S_DEL_SHRD;
            S_GET_TAKE: n_state = S_FINISH;
            S_LOC_RD:   n_state = i_status.j_lt_len ? S_LOC_CMP : S_FINISH;
            S_LOC_CMP:  n_state = i_status.match ? S_FINISH : S_LOC_RD;
            S_FINISH: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // Commands per state
    always_comb begin
        o_cmd            = '0;
        o_cmd.j_op       = J_HOLD;
        o_cmd.rd_sel     = RA_J;
        o_cmd.wr_sel     = WA_J_SHIFT;
        o_cmd.len_op     = LEN_HOLD;
        o_stall          = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                o_cmd.load_item = i_valid;
            end
            S_DECODE: begin
                case (i_status.action)
                    ACT_INSERT: begin
                        o_cmd.j_op = J_LOAD_LEN;
                    end
                    ACT_DELETE: begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = RA_POS_M1;
                        o_cmd.j_op   = J_LOAD_POS;
                    end
                    ACT_GET: begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = RA_POS_M1;
                    end
                    default: begin
                        o_cmd.j_op = J_LOAD_ZERO;
                    end
                endcase
            end
            S_INS_RD: begin
                // read the entry to move up, or drop the new value in place
                if (i_status.j_ge_pos) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RA_J_M1;
                end else begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = WA_POS_M1_VALUE;
                    o_cmd.len_op = LEN_INC;
                    o_cmd.set_ok = 1'b1;
                end
            end
            S_INS_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WA_J_SHIFT;
                o_cmd.j_op   = J_DEC;
            end
            S_DEL_TAKE: begin
                o_cmd.capture_rv = 1'b1;
                o_cmd.set_ok     = 1'b1;
            end
            S_DEL_SHRD: begin
                // read the entry to move down, or shorten the list when done
                if (i_status.j_lt_len) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RA_J;
                end else begin
                    o_cmd.len_op = LEN_DEC;
                end
            end
            S_DEL_SHWR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WA_J_M1_SHIFT;
                o_cmd.j_op   = J_INC;
            end
            S_GET_TAKE: begin
                o_cmd.capture_rv = 1'b1;
                o_cmd.set_ok     = 1'b1;
            end
            S_LOC_RD: begin
                if (i_status.j_lt_len) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RA_J;
                end
            end
            S_LOC_CMP: begin
                if (i_status.match) begin
                    o_cmd.set_ok = 1'b1;
                    o_cmd.set_rp = 1'b1;
                end else begin
                    o_cmd.j_op = J_INC;
                end
            end
            S_FINISH: begin
                o_cmd.out_load = i_status.out_free;
            end
            default: begin
                o_cmd.load_item = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/positional_array_list_core.sv =====
// Top level of the positional array list: controller plus datapath.
// The block keeps an ordered list of up to CAPACITY signed 32-bit values in a
// single-port-style memory (one write, one registered read per cycle) and runs
// one item at a time. Each entry that is moved takes a memory read followed by a
// write; locate reads and compares each entry that it examines. An insert, delete
// or get that fails its position or capacity check goes straight to the finish
// step. The finish step waits for as long as an earlier result still waits in
// the output register, since only one result is held. The next item is taken
// once the result sits in the output register, even while that result still
// waits to be taken. Positions are 1-based; count reports the length after the
// action.
`default_nettype none

module positional_array_list_core #(
    parameter int CAPACITY = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  pal_pkg::t_in_item   i_item,
    output logic                o_valid,
    input  wire                 i_stall,
    output pal_pkg::t_out_item  o_item
);
    import pal_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequence each item
    pal_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_stall  (o_stall),
        .o_cmd    (cmd)
    );

    // Hold entries, length and results
    pal_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .i_stall  (i_stall),
        .o_status (status),
        .o_valid  (o_valid),
        .o_item   (o_item)
    );

endmodule

`default_nettype wire
